FILE: hw/rtl/acef_pkg.sv
// ----------------------------------------------------------------------------
// acef_pkg: shared types and constants of the escape sequence filter
// Character codes, field widths and the result record passed from the
// sequence scanner to the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

package acef_pkg;

	localparam int UNIT_W          = 16;
	localparam int REP_W           = 11;
	localparam int MAX_ADVANCE_DEF = 1024;
	localparam int S_DATA_W        = 16;
	localparam int M_DATA_W        = 32;

	// character codes
	localparam logic [UNIT_W-1:0] CH_CSI8   = 16'h00A2;
	localparam logic [UNIT_W-1:0] CH_ARROW  = 16'h2190;
	localparam logic [UNIT_W-1:0] CH_LBRACK = 16'h005B;
	localparam logic [UNIT_W-1:0] CH_SEMI   = 16'h003B;
	localparam logic [UNIT_W-1:0] CH_FWD    = 16'h0043;
	localparam logic [UNIT_W-1:0] CH_SPACE  = 16'h0020;
	localparam logic [UNIT_W-1:0] CH_ZERO   = 16'h0030;
	localparam logic [UNIT_W-1:0] CH_NINE   = 16'h0039;

	// one result item
	typedef struct packed {
		logic [UNIT_W-1:0] unit;
		logic [REP_W-1:0]  rep;
		logic              last;
	} acef_res_t;

	// everything one input transaction produces
	typedef struct packed {
		acef_res_t   res0;
		acef_res_t   res1;
		logic [1:0]  count;
	} acef_step_t;

endpackage

`default_nettype wire

FILE: hw/rtl/acef_scan.sv
// ----------------------------------------------------------------------------
// acef_scan: escape sequence scanner
// Holds the scan state and turns one character into up to two result items.
// The state advances only when the transaction is handed to the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module acef_scan #(
	parameter int MAX_ADVANCE = acef_pkg::MAX_ADVANCE_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      advance,
	input  wire logic [acef_pkg::UNIT_W-1:0] unit,
	input  wire logic                      eot,
	output acef_pkg::acef_step_t           step
);
	import acef_pkg::*;

	localparam int NUM_W = $clog2(MAX_ADVANCE + 1);
	localparam int PRD_W = NUM_W + 4;

	localparam logic [1:0] MODE_PLAIN   = 2'd0;
	localparam logic [1:0] MODE_PENDING = 2'd1;
	localparam logic [1:0] MODE_NUMBER  = 2'd2;
	localparam logic [1:0] MODE_REST    = 2'd3;

	logic [1:0]       mode_q, mode_d;
	logic [NUM_W-1:0] num_q, num_d;
	logic             dig_q, dig_d;

	logic             is_digit;
	logic [PRD_W-1:0] prod;
	logic [NUM_W-1:0] num_sat;
	logic [NUM_W-1:0] cnt;
	logic             plain, p_emit, e_arrow, first_v;
	logic [UNIT_W-1:0] first_u;
	logic [REP_W-1:0]  first_rep;

	// digit accumulation with saturation
	assign is_digit = (unit >= CH_ZERO) && (unit <= CH_NINE);
	assign prod = {1'b0, num_q, 3'b000} + {3'b000, num_q, 1'b0} +
		{{(PRD_W-4){1'b0}}, unit[3:0]};
	assign num_sat = (prod > PRD_W'(MAX_ADVANCE)) ? NUM_W'(MAX_ADVANCE) : prod[NUM_W-1:0];

	// repeat count of a cursor forward, at least one
	assign cnt      = (num_q == '0) ? NUM_W'(1) : num_q;

	// next state and results
	always_comb begin
		mode_d    = mode_q;
		num_d     = num_q;
		dig_d     = dig_q;
		plain     = 1'b0;
		first_v   = 1'b0;
		first_u   = CH_ARROW;
		first_rep = REP_W'(1);
		p_emit    = 1'b0;
		e_arrow   = 1'b0;
		step      = '0;

		case (mode_q)
			MODE_PENDING: begin
				if (unit == CH_LBRACK) begin
					mode_d = MODE_NUMBER;
					num_d  = '0;
					dig_d  = 1'b0;
				end else begin
					first_v = 1'b1;
					mode_d  = MODE_PLAIN;
					plain   = 1'b1;
				end
			end
			MODE_NUMBER, MODE_REST: begin
				if (is_digit) begin
					if (mode_q == MODE_NUMBER) begin
						num_d = num_sat;
					end
					dig_d = 1'b1;
				end else if (unit == CH_SEMI) begin
					dig_d  = 1'b1;
					mode_d = MODE_REST;
				end else if (dig_q) begin
					if (unit == CH_FWD) begin
						first_v   = 1'b1;
						first_u   = CH_SPACE;
						first_rep = REP_W'(cnt);
					end
					mode_d = MODE_PLAIN;
					num_d  = '0;
					dig_d  = 1'b0;
				end else begin
					mode_d = MODE_PLAIN;
					num_d  = '0;
					dig_d  = 1'b0;
					plain  = 1'b1;
				end
			end
			default: begin
				plain = 1'b1;
			end
		endcase

		// ordinary text, which may open a new sequence
		if (plain) begin
			if (unit == CH_CSI8) begin
				mode_d = MODE_NUMBER;
				num_d  = '0;
				dig_d  = 1'b0;
			end else if (unit == CH_ARROW) begin
				mode_d = MODE_PENDING;
			end else begin
				p_emit = 1'b1;
			end
		end

		// end of text: flush a pending arrow, drop an open sequence
		if (eot) begin
			e_arrow = (mode_d == MODE_PENDING);
			mode_d  = MODE_PLAIN;
			num_d   = '0;
			dig_d   = 1'b0;
		end

		// pack the results in order
		if (first_v) begin
			step.res0.unit = first_u;
			step.res0.rep  = first_rep;
			step.res1.unit = p_emit ? unit : CH_ARROW;
			step.res1.rep  = REP_W'(1);
			step.count     = (p_emit || e_arrow) ? 2'd2 : 2'd1;
		end else begin
			step.res0.unit = p_emit ? unit : CH_ARROW;
			step.res0.rep  = REP_W'(1);
			step.res1.unit = CH_ARROW;
			step.res1.rep  = REP_W'(1);
			step.count     = (p_emit || e_arrow) ? 2'd1 : 2'd0;
		end
		step.res0.last = (step.count == 2'd1);
		step.res1.last = 1'b1;
	end

	// hold the scan state until the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PLAIN;
			num_q  <= '0;
			dig_q  <= 1'b0;
		end else if (advance) begin
			mode_q <= mode_d;
			num_q  <= num_d;
			dig_q  <= dig_d;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/acef_outq.sv
// ----------------------------------------------------------------------------
// acef_outq: two-entry result queue
// Takes up to two result items per cycle and presents them one per cycle on
// the master stream side while the receiver accepts them.
// ----------------------------------------------------------------------------
`default_nettype none

module acef_outq (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [1:0]                    push_n,
	input  wire acef_pkg::acef_res_t           res0,
	input  wire acef_pkg::acef_res_t           res1,
	output logic [1:0]                         room,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [acef_pkg::M_DATA_W-1:0]      m_tdata,  // out_unit[15:0], repeat_res[26:16]
	output logic                               m_tlast   // last_of_run
);
	import acef_pkg::*;

	acef_res_t  slot0_q, slot1_q;
	acef_res_t  kept0;
	logic [1:0] cnt_q, cnt_kept;
	logic       pop;

	assign m_tvalid = (cnt_q != 2'd0);
	assign pop      = m_tvalid && m_tready;
	assign kept0    = pop ? slot1_q : slot0_q;
	assign cnt_kept = cnt_q - {1'b0, pop};
	assign room     = 2'd2 - cnt_kept;

	assign m_tdata = {{(M_DATA_W-UNIT_W-REP_W){1'b0}}, slot0_q.rep, slot0_q.unit};
	assign m_tlast = slot0_q.last;

	// count of held items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_kept + push_n;
		end
	end

	// shift on a pop, append new items behind the kept ones
	always_ff @(posedge clk) begin
		case (cnt_kept)
			2'd0: begin
				slot0_q <= res0;
				slot1_q <= res1;
			end
			2'd1: begin
				slot0_q <= kept0;
				slot1_q <= res0;
			end
			default: begin
				slot0_q <= slot0_q;
				slot1_q <= slot1_q;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: hw/rtl/ansi_cursor_escape_filter.sv
// ----------------------------------------------------------------------------
// ansi_cursor_escape_filter: text filter that strips ANSI control sequences
//
// Slave stream: one 16-bit code unit per transaction in s_tdata, s_tlast
// marks the final character of the text. Master stream: one result per
// transaction, the character in m_tdata[15:0], its repeat count in
// m_tdata[26:16], m_tlast on the last result caused by an input character.
// A cursor-forward sequence becomes one space with a repeat count; other
// sequences vanish, but a final character right after the opening is text.
// A character is registered in the input stage, scanned combinationally,
// and its results are written into the result queue once it has room.
// Throughput: one character per cycle while each yields at most one result
// and the receiver is ready; a character yielding two results may hold the
// input stage until the queue has room, set by the single master port.
// Reset clears the scan state and empties both stages. When the receiver
// stalls, the two-entry result queue fills, then the input stage holds and
// s_tready falls; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module ansi_cursor_escape_filter #(
	parameter int MAX_ADVANCE = acef_pkg::MAX_ADVANCE_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [acef_pkg::S_DATA_W-1:0] s_tdata,  // code_unit[15:0]
	input  wire logic                          s_tlast,  // end_of_text
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [acef_pkg::M_DATA_W-1:0]      m_tdata,  // out_unit[15:0], repeat_res[26:16]
	output logic                               m_tlast   // last_of_run
);
	import acef_pkg::*;

	logic              valid_s1;
	logic [UNIT_W-1:0] unit_s1;
	logic              eot_s1;
	acef_step_t        step;
	logic [1:0]        room;
	logic              advance;
	logic [1:0]        push_n;

	// process the held character once the queue has room for its results
	assign advance  = valid_s1 && (step.count <= room);
	assign push_n   = advance ? step.count : 2'd0;
	assign s_tready = !valid_s1 || advance;

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			unit_s1 <= s_tdata[UNIT_W-1:0];
			eot_s1  <= s_tlast;
		end
	end

	acef_scan #(
		.MAX_ADVANCE(MAX_ADVANCE)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.unit    (unit_s1),
		.eot     (eot_s1),
		.step    (step)
	);

	acef_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_n   (push_n),
		.res0     (step.res0),
		.res1     (step.res1),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire
